[sv/wsim_pkg.sv]
// ----------------------------------------------------------------------------
// wsim_pkg
// shared types and constants of the working-set interval monitor
// ----------------------------------------------------------------------------
package wsim_pkg;

   // field widths
   localparam int ELEM_W     = 24;
   localparam int PSIZE_W    = 16;
   localparam int ILEN_W     = 16;
   localparam int NPAGES_W   = 11;
   localparam int TOTAL_W    = 32;
   localparam int DIST_W     = 11;
   localparam int DIV_CNT_W  = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 96;

   // register reset values
   localparam logic [PSIZE_W-1:0]  PAGE_SIZE_RST    = 16'd16;
   localparam logic [ILEN_W-1:0]   INTERVAL_LEN_RST = 16'd2000;
   localparam logic [NPAGES_W-1:0] NUM_PAGES_RST    = 11'd63;

   localparam logic [DIST_W-1:0]   DISTINCT_MAX     = 11'd2047;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SIZE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_LEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_PAGES    = 2'd2;

   // request kinds
   localparam logic OP_REF   = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic load;       // capture request transaction
      logic div_step;   // one quotient bit
      logic ill_inc;    // count an illegal reference
      logic ram_rd;     // read bitmap at page
      logic rmw;        // set page bit, count reference
      logic rpt_load;   // load report, close interval
      logic clr_step;   // clear one bitmap entry
   } cmd_type;

   typedef struct packed {
      logic is_flush;
      logic div_last;
      logic legal;
      logic interval_zero;
      logic report_due;
      logic rsp_free;
      logic clr_last;
   } status_type;

endpackage

[sv/working_set_interval_monitor.sv]
// ----------------------------------------------------------------------------
// working_set_interval_monitor
// working-set size over fixed intervals of memory references
// ----------------------------------------------------------------------------
// Each request transaction is either a memory reference (tuser 0, element
// index in tdata) or an end-of-trace flush (tuser 1). A reference is divided
// by page_size in a restoring divider, one quotient bit per cycle, and its
// page is then checked: a legal page is read and set in the bitmap, an
// illegal one is counted; a flush with no pending legal references returns
// to idle. When an interval closes (its count of legal references reaches
// interval_len, or a flush arrives with legal references pending) a report
// transaction is loaded into an output register once that register is free,
// and the page bitmap ram is then cleared one entry per cycle, all NUM_PAGES
// entries, before the next request is taken. The same clear pass runs after
// reset. Configuration writes are taken every cycle and must only be issued
// while the block is idle.
// ----------------------------------------------------------------------------
module working_set_interval_monitor #(
   parameter int NUM_PAGES = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,

   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [wsim_pkg::REQ_DATA_W-1:0]       req_tdata,   // [23:0] element_index
   input  logic                                  req_tuser,   // [0] op

   // report stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [31:0] interval_start, [47:32] refs_in_interval, [58:48] distinct_pages,
   // [90:59] illegal_total, [95:91] zero
   output logic [wsim_pkg::RSP_DATA_W-1:0]       rsp_tdata,

   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [wsim_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wsim_pkg::CSR_DATA_W-1:0]       csr_data
);
   import wsim_pkg::*;

   // configuration registers
   logic [PSIZE_W-1:0]  page_size_ff;
   logic [ILEN_W-1:0]   interval_len_ff;
   logic [NPAGES_W-1:0] num_pages_ff;

   cmd_type    cmd;
   status_type status;

   // write channel never stalls
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff    <= PAGE_SIZE_RST;
         interval_len_ff <= INTERVAL_LEN_RST;
         num_pages_ff    <= NUM_PAGES_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PAGE_SIZE: begin
               page_size_ff <= csr_data[PSIZE_W-1:0];
            end
            CSR_INTERVAL_LEN: begin
               interval_len_ff <= csr_data[ILEN_W-1:0];
            end
            CSR_NUM_PAGES: begin
               num_pages_ff <= csr_data[NPAGES_W-1:0];
            end
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   // sequencer
   wsim_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // divider, bitmap, counters and report register
   wsim_dp #(
      .NUM_PAGES (NUM_PAGES)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_op       (req_tuser),
      .req_elem     (req_tdata[ELEM_W-1:0]),
      .page_size    (page_size_ff),
      .interval_len (interval_len_ff),
      .num_pages    (num_pages_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

[sv/wsim_ram.sv]
// ----------------------------------------------------------------------------
// wsim_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module wsim_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/wsim_ctrl.sv]
// ----------------------------------------------------------------------------
// wsim_ctrl
// sequencer: divide, bitmap update, report and bitmap clear pass
// ----------------------------------------------------------------------------
module wsim_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  wsim_pkg::status_type status,
   output wsim_pkg::cmd_type    cmd
);
   import wsim_pkg::*;

   typedef enum logic [2:0] {
      CLEAR,
      IDLE,
      START,
      DIVIDE,
      CHECK,
      UPDATE,
      DECIDE,
      REPORT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = START;
            end
         end
         START: begin
            if (!status.is_flush) begin
               state_in = DIVIDE;
            end else if (status.interval_zero) begin
               state_in = IDLE;
            end else begin
               state_in = REPORT;
            end
         end
         DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = CHECK;
            end
         end
         CHECK: begin
            if (status.legal) begin
               cmd.ram_rd = 1'b1;
               state_in   = UPDATE;
            end else begin
               cmd.ill_inc = 1'b1;
               state_in    = IDLE;
            end
         end
         UPDATE: begin
            cmd.rmw  = 1'b1;
            state_in = DECIDE;
         end
         DECIDE: begin
            state_in = status.report_due ? REPORT : IDLE;
         end
         REPORT: begin
            if (status.rsp_free) begin
               cmd.rpt_load = 1'b1;
               state_in     = CLEAR;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == IDLE);

   // bitmap is only updated right after a legal page check
   assert property (@(posedge clock) disable iff (reset)
      state_ff == UPDATE |-> $past(state_ff) == CHECK)
      else $error("bitmap update without page check");

   // a report comes only from a flush, a full interval or a stalled report
   assert property (@(posedge clock) disable iff (reset)
      state_ff == REPORT |-> ($past(state_ff) == START || $past(state_ff) == DECIDE ||
                             $past(state_ff) == REPORT))
      else $error("unexpected entry into report");

   // clear pass runs to its last entry
   assert property (@(posedge clock) disable iff (reset)
      state_ff == CLEAR && !status.clr_last |=> state_ff == CLEAR)
      else $error("clear pass cut short");

endmodule

[sv/wsim_dp.sv]
// ----------------------------------------------------------------------------
// wsim_dp
// datapath: page divider, bitmap, interval counters and report register
// ----------------------------------------------------------------------------
module wsim_dp #(
   parameter int NUM_PAGES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  wsim_pkg::cmd_type                   cmd,
   output wsim_pkg::status_type                status,
   input  logic                                req_op,
   input  logic [wsim_pkg::ELEM_W-1:0]         req_elem,
   input  logic [wsim_pkg::PSIZE_W-1:0]        page_size,
   input  logic [wsim_pkg::ILEN_W-1:0]         interval_len,
   input  logic [wsim_pkg::NPAGES_W-1:0]       num_pages,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [wsim_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import wsim_pkg::*;

   localparam int PAGE_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int DCNT_W = $clog2(NUM_PAGES + 1);

   // divider
   logic                 op_ff;
   logic [PSIZE_W-1:0]   div_ff;
   logic [ELEM_W-1:0]    quo_ff,  quo_in;
   logic [PSIZE_W-1:0]   rem_ff,  rem_in;
   logic [DIV_CNT_W-1:0] dcnt_ff;
   logic [PSIZE_W:0]     rem_shift;
   logic [PSIZE_W:0]     rem_diff;

   // counters
   logic [ILEN_W-1:0]    interval_ff;
   logic [TOTAL_W-1:0]   total_ff;
   logic [TOTAL_W-1:0]   illegal_ff;
   logic [DCNT_W-1:0]    distinct_ff;
   logic [TOTAL_W:0]     total_sum;
   logic [TOTAL_W-1:0]   distinct_ext;
   logic [DIST_W-1:0]    distinct_sat;

   // bitmap
   logic [PAGE_W-1:0]    page;
   logic [PAGE_W-1:0]    clr_addr_ff;
   logic                 ram_wr_en;
   logic [PAGE_W-1:0]    ram_wr_addr;
   logic                 ram_wr_data;
   logic                 ram_rd_data;

   // report register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   // restoring divide, one quotient bit per step
   always_comb begin
      rem_shift = {rem_ff, quo_ff[ELEM_W-1]};
      rem_diff  = rem_shift - {1'b0, div_ff};
      if (rem_shift >= {1'b0, div_ff}) begin
         rem_in = rem_diff[PSIZE_W-1:0];
         quo_in = {quo_ff[ELEM_W-2:0], 1'b1};
      end else begin
         rem_in = rem_shift[PSIZE_W-1:0];
         quo_in = {quo_ff[ELEM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         div_ff <= (page_size == '0) ? PSIZE_W'(1) : page_size;
         quo_ff <= req_elem;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.load) begin
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + DIV_CNT_W'(1);
      end
   end

   assign page = quo_ff[PAGE_W-1:0];

   assign ram_wr_en   = cmd.rmw || cmd.clr_step;
   assign ram_wr_addr = cmd.clr_step ? clr_addr_ff : page;
   assign ram_wr_data = cmd.rmw;

   wsim_ram #(
      .WIDTH (1),
      .DEPTH (NUM_PAGES)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.ram_rd),
      .rd_addr (page),
      .rd_data (ram_rd_data)
   );

   assign total_sum    = {1'b0, total_ff} + {{(TOTAL_W+1-ILEN_W){1'b0}}, interval_ff};
   assign distinct_ext = TOTAL_W'(distinct_ff);
   assign distinct_sat = (distinct_ext > TOTAL_W'(DISTINCT_MAX)) ? DISTINCT_MAX
                                                                 : distinct_ext[DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= '0;
         total_ff    <= '0;
         illegal_ff  <= '0;
         distinct_ff <= '0;
         clr_addr_ff <= '0;
      end else begin
         if (cmd.ill_inc && (illegal_ff != '1)) begin
            illegal_ff <= illegal_ff + TOTAL_W'(1);
         end
         if (cmd.rmw) begin
            if (interval_ff != '1) begin
               interval_ff <= interval_ff + ILEN_W'(1);
            end
            if (!ram_rd_data) begin
               distinct_ff <= distinct_ff + DCNT_W'(1);
            end
         end
         if (cmd.rpt_load) begin
            total_ff    <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
            interval_ff <= '0;
            distinct_ff <= '0;
            clr_addr_ff <= '0;
         end else if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + PAGE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rpt_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rpt_load) begin
         rsp_data_ff <= {5'b0, illegal_ff, distinct_sat, interval_ff, total_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign status.is_flush      = (op_ff == OP_FLUSH);
   assign status.div_last      = (dcnt_ff == DIV_CNT_W'(ELEM_W - 1));
   assign status.legal         = (quo_ff < ELEM_W'(num_pages)) && (quo_ff < ELEM_W'(NUM_PAGES));
   assign status.interval_zero = (interval_ff == '0);
   assign status.report_due    = (interval_ff >= interval_len);
   assign status.rsp_free      = !rsp_valid_ff || rsp_tready;
   assign status.clr_last      = (clr_addr_ff == PAGE_W'(NUM_PAGES - 1));

   // closing an interval resets its count and presents a report
   assert property (@(posedge clock) disable iff (reset)
      cmd.rpt_load |=> (interval_ff == '0) && rsp_valid_ff)
      else $error("interval not closed after report");

   // saturating totals never move backward
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> illegal_ff >= $past(illegal_ff))
      else $error("illegal total decreased");

   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> total_ff >= $past(total_ff))
      else $error("reference total decreased");

endmodule
